// ===== design/moving_window_statistics_core_defines.svh =====
// ----------------------------------------------------------------------------
// moving window statistics assertion macros
// shared assertion forms with clock and reset built in
// ----------------------------------------------------------------------------
`ifndef MOVING_WINDOW_STATISTICS_CORE_DEFINES_SVH
`define MOVING_WINDOW_STATISTICS_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg
// shared constants and types of the moving window statistics core
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int unsigned MaxWindow  = 512;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned PosW       = $clog2(MaxWindow);
  localparam int unsigned LenW       = 10;
  localparam int unsigned CntW       = 10;
  localparam int unsigned SumW       = 25;
  localparam int unsigned SqW        = 40;
  localparam int unsigned OutW       = 16;
  // deviation numerator n*sq - sum^2 fits 50 bits, quotient of /n^2 fits 32
  localparam int unsigned NumW       = 52;
  localparam int unsigned QW         = 32;
  localparam int unsigned DivW       = 20;
  localparam int unsigned DivStepW   = $clog2(NumW + 1);
  // shift and add multiply, one multiplier bit per cycle
  localparam int unsigned MulSteps   = SumW;
  localparam int unsigned MulCntW    = $clog2(MulSteps + 2);

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StUpdate,
    StMul,
    StDivMean,
    StDivRms,
    StDivDev1,
    StDivDev2,
    StSqrtRms,
    StSqrtDev,
    StOut
  } state_e;

  typedef struct packed {
    logic        start;
    logic [NumW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/mws_if.sv =====
// ----------------------------------------------------------------------------
// mws_if
// valid ready channel carrying a payload of generic type
// ----------------------------------------------------------------------------
interface mws_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mws_div.sv =====
// ----------------------------------------------------------------------------
// mws_div
// bit serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mws_div
  import mws_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [NumW-1:0]     num_q, num_d;
  logic [DivW:0]       rem_q, rem_d;
  logic [DivW-1:0]     den_q, den_d;
  logic [DivStepW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [DivW:0]       shifted;

  assign shifted = {rem_q[DivW-1:0], num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = DivStepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivStepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = num_q;

endmodule

// ===== design/mws_sqrt.sv =====
// ----------------------------------------------------------------------------
// mws_sqrt
// digit serial floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module mws_sqrt
  import mws_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [QW-1:0]   rad_i,
  output logic            busy_o,
  output logic [OutW-1:0] root_o
);

  localparam int unsigned StepW = $clog2(OutW + 1);

  logic [QW-1:0]    rad_q, rad_d;
  logic [OutW+1:0]  rem_q, rem_d;
  logic [OutW-1:0]  root_q, root_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [OutW+1:0]  trial, cur;

  assign cur   = {rem_q[OutW-1:0], rad_q[QW-1:QW-2]};
  assign trial = {root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = StepW'(OutW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[QW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_q[OutW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_q[OutW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== design/moving_window_statistics_core.sv =====
// push: shift and add multiply, four divides, two roots
// flow: one transaction at a time, the next input is accepted only
// after the result moves to the output registers
// reset: asynchronous active low, totals and count zero, window length 512
// the sample ring is not cleared, entries are read only after being written
// ----------------------------------------------------------------------------
// moving_window_statistics_core
// sliding window mean, rms and standard deviation over signed samples
// ----------------------------------------------------------------------------
`include "moving_window_statistics_core_defines.svh"

module moving_window_statistics_core
  import mws_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  mws_if.sink             in_if,
  mws_if.source           out_if
);

  logic [SampleBits-1:0] mem [MaxWindow];
  logic [SampleBits-1:0] rd_q;

  state_e state_q, state_d;

  logic [LenW-1:0]       len_q;
  logic [PosW-1:0]       wpos_q;
  logic [CntW-1:0]       cnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]        sq_q;
  logic                  cmd_q;
  logic signed [SampleBits-1:0] smp_q;
  logic signed [2*SampleBits-1:0] rd_sq, smp_sq;

  logic [CntW-1:0]       efflen;
  logic [PosW-1:0]       old_pos;
  logic [SumW-1:0]       mag;
  logic [NumW-1:0]       num_q;
  logic [NumW-1:0]       nsq_q, ssq_q;
  logic [NumW-1:0]       adda_q, addb_q;
  logic [CntW-1:0]       mca_q;
  logic [SumW-1:0]       mcb_q;
  logic [MulCntW-1:0]    mstep_q;
  logic [NumW-1:0]       quo_q;
  logic [OutW-1:0]       mean_q, rms_q, dev_q;
  logic                  full_q;
  logic                  ovalid_q;
  logic                  out_load;
  logic [OutW-1:0]       omean_q, orms_q, odev_q;
  logic [CntW-1:0]       ocnt_q;
  logic                  ofull_q;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     sq_start, sq_busy;
  logic [OutW-1:0] sq_root;
  logic [QW-1:0]   sq_rad;
  logic     dbusy_prev_q, sbusy_prev_q;
  logic     div_done, sq_done;
  logic     busy_start_q;

  always_comb begin
    if (len_q == '0) begin
      efflen = CntW'(1);
    end else if (len_q > CntW'(MaxWindow)) begin
      efflen = CntW'(MaxWindow);
    end else begin
      efflen = len_q;
    end
  end

  assign old_pos = wpos_q - cnt_q[PosW-1:0];
  assign mag     = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign rd_sq   = signed'(rd_q) * signed'(rd_q);
  assign smp_sq  = smp_q * smp_q;

  assign in_if.ready = (state_q == StIdle);
  assign div_done    = dbusy_prev_q && !drsp.busy;
  assign sq_done     = sbusy_prev_q && !sq_busy;
  assign out_load    = (state_q == StOut) && (!ovalid_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_if.valid && in_if.ready) state_d = StRead;
      StRead:    state_d = StUpdate;
      StUpdate:  state_d = StMul;
      StMul: begin
        if (cnt_q == '0) begin
          state_d = StOut;
        end else if (mstep_q == '0) begin
          state_d = StDivMean;
        end
      end
      StDivMean: if (div_done) state_d = StDivRms;
      StDivRms:  if (div_done) state_d = StSqrtRms;
      StSqrtRms: if (sq_done) state_d = StDivDev1;
      StDivDev1: if (div_done) state_d = StDivDev2;
      StDivDev2: if (div_done) state_d = StSqrtDev;
      StSqrtDev: if (sq_done) state_d = StOut;
      StOut:     if (out_load) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = DivW'(cnt_q);
    sq_start   = 1'b0;
    sq_rad     = quo_q[QW-1:0];
    unique case (state_q)
      StDivMean: begin
        dreq.start = busy_start_q;
        dreq.num   = NumW'(mag);
      end
      StDivRms: begin
        dreq.start = busy_start_q;
        dreq.num   = NumW'(sq_q);
      end
      StSqrtRms: sq_start = busy_start_q;
      StDivDev1: begin
        dreq.start = busy_start_q;
        dreq.num   = num_q;
      end
      StDivDev2: begin
        dreq.start = busy_start_q;
        dreq.num   = quo_q;
      end
      StSqrtDev: sq_start = busy_start_q;
      default: ;
    endcase
  end

  mws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  mws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    rd_q <= mem[old_pos];
    if (state_q == StUpdate && cmd_q == CmdPush) begin
      mem[wpos_q] <= smp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      len_q        <= LenW'(MaxWindow);
      wpos_q       <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
      sq_q         <= '0;
      ovalid_q     <= 1'b0;
      dbusy_prev_q <= 1'b0;
      sbusy_prev_q <= 1'b0;
      busy_start_q <= 1'b0;
      mstep_q      <= '0;
    end else begin
      state_q      <= state_d;
      dbusy_prev_q <= drsp.busy;
      sbusy_prev_q <= sq_busy;
      busy_start_q <= (state_d != state_q);
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (out_if.valid && out_if.ready) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == StUpdate) begin
        mstep_q <= MulCntW'(MulSteps + 1);
        if (cmd_q == CmdClear) begin
          wpos_q <= '0;
          cnt_q  <= '0;
          sum_q  <= '0;
          sq_q   <= '0;
        end else begin
          wpos_q <= wpos_q + 1'b1;
          if (cnt_q >= efflen) begin
            sum_q <= sum_q - SumW'(signed'(rd_q)) + SumW'(smp_q);
            sq_q  <= sq_q - SqW'($unsigned(rd_sq)) + SqW'($unsigned(smp_sq));
          end else begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + SumW'(smp_q);
            sq_q  <= sq_q + SqW'($unsigned(smp_sq));
          end
        end
      end else if (state_q == StMul && mstep_q != '0) begin
        mstep_q <= mstep_q - 1'b1;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end
    end
  end

  // n*sq and sum^2 by shift and add, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      cmd_q <= in_if.data.command;
      smp_q <= in_if.data.sample;
    end
    if (state_q == StMul) begin
      if (mstep_q == MulCntW'(MulSteps + 1)) begin
        mca_q  <= cnt_q;
        mcb_q  <= mag;
        adda_q <= NumW'(sq_q);
        addb_q <= NumW'(mag);
        nsq_q  <= '0;
        ssq_q  <= '0;
      end else if (mstep_q != '0) begin
        if (mca_q[0]) begin
          nsq_q <= nsq_q + adda_q;
        end
        if (mcb_q[0]) begin
          ssq_q <= ssq_q + addb_q;
        end
        mca_q  <= mca_q >> 1;
        mcb_q  <= mcb_q >> 1;
        adda_q <= adda_q << 1;
        addb_q <= addb_q << 1;
      end else begin
        num_q <= nsq_q - ssq_q;
      end
      mean_q <= '0;
      rms_q  <= '0;
      dev_q  <= '0;
      full_q <= (cnt_q >= efflen);
    end
    if (div_done) begin
      quo_q <= drsp.quo;
      if (state_q == StDivMean) begin
        mean_q <= sum_q[SumW-1] ? OutW'(-drsp.quo) : OutW'(drsp.quo);
      end
    end
    if (sq_done) begin
      if (state_q == StSqrtRms) begin
        rms_q <= sq_root;
      end else begin
        dev_q <= sq_root;
      end
    end
    if (out_load) begin
      omean_q <= mean_q;
      orms_q  <= rms_q;
      odev_q  <= dev_q;
      ocnt_q  <= cnt_q;
      ofull_q <= full_q;
    end
  end

  assign out_if.valid              = ovalid_q;
  assign out_if.data.mean          = omean_q;
  assign out_if.data.rms           = orms_q;
  assign out_if.data.deviation     = odev_q;
  assign out_if.data.sample_count  = ocnt_q;
  assign out_if.data.window_full   = ofull_q;

  `MWS_ASSERT_IMP(a_ready_idle, in_if.ready, state_q == StIdle, "ready outside idle")
  `MWS_ASSERT_NEXT(a_out_after_done, state_q == StOut, out_if.valid, "result lost")
  `MWS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(MaxWindow), "count overflow")

endmodule

// ===== bench/mws_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_tb_pkg
// transaction layouts of the sample and statistics channels
// ----------------------------------------------------------------------------
package mws_tb_pkg;

  import mws_pkg::*;

  typedef struct packed {
    logic                  command;
    logic [SampleBits-1:0] sample;
  } sample_in_t;

  typedef struct packed {
    logic [OutW-1:0] mean;
    logic [OutW-1:0] rms;
    logic [OutW-1:0] deviation;
    logic [CntW-1:0] sample_count;
    logic            window_full;
  } stats_out_t;

endpackage

// ===== bench/moving_window_statistics_core_checker.sv =====
// ----------------------------------------------------------------------------
// moving_window_statistics_core_checker
// watches the sample, statistics and register ports, keeps its own window
// and totals, and compares every statistics transaction in order
// ----------------------------------------------------------------------------
module moving_window_statistics_core_checker
  import mws_pkg::*;
  import mws_tb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  sample_in_t      in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  stats_out_t      out_data_i,
  output int              pending_o,
  output int              errors_o
);

  int              ring [MaxWindow];
  int unsigned     wr_pos;
  int unsigned     held;
  longint          win_sum;
  longint          win_sq;
  logic [LenW-1:0] win_len;
  stats_out_t      stats_q [$];
  int              err_cnt = 0;

  assign pending_o = stats_q.size();
  assign errors_o  = err_cnt;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void predict_stats(sample_in_t item);
    int unsigned     eff;
    int              s;
    int              leaving;
    int unsigned     oldest;
    longint          n;
    longint unsigned mag;
    longint unsigned var_num;
    stats_out_t      exp_stats;
    eff = (win_len == 0) ? 1 : ((win_len > MaxWindow) ? MaxWindow : win_len);
    if (item.command == CmdClear) begin
      wr_pos = 0;
      held = 0;
      win_sum = 0;
      win_sq = 0;
    end else begin
      s = $signed(item.sample);
      if (held >= eff) begin
        oldest = (wr_pos >= held) ? wr_pos - held : wr_pos + MaxWindow - held;
        leaving = ring[oldest % MaxWindow];
        win_sum -= leaving;
        win_sq -= longint'(leaving) * leaving;
      end else begin
        held++;
      end
      win_sum += s;
      win_sq += longint'(s) * s;
      ring[wr_pos % MaxWindow] = s;
      wr_pos = (wr_pos + 1 >= MaxWindow) ? 0 : wr_pos + 1;
    end
    exp_stats = '0;
    if (held != 0) begin
      n = held;
      mag = (win_sum < 0) ? -win_sum : win_sum;
      exp_stats.mean = OutW'(win_sum / n);
      exp_stats.rms = OutW'(floor_root(longint'(win_sq) / n));
      var_num = longint'(n * win_sq) - mag * mag;
      exp_stats.deviation = OutW'(floor_root(var_num / longint'(n * n)));
    end
    exp_stats.sample_count = CntW'(held);
    exp_stats.window_full = (held >= eff);
    stats_q.push_back(exp_stats);
  endfunction

  task automatic report(string field, longint got, longint want);
    err_cnt++;
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, field, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_out_t want;
    if (!rst_ni) begin
      wr_pos = 0;
      held = 0;
      win_sum = 0;
      win_sq = 0;
      win_len = 10'd512;
    end else begin
      if (cfg_we_i) win_len = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_stats(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = stats_q.pop_front();
          if (out_data_i.mean !== want.mean)
            report("mean", $signed(out_data_i.mean), $signed(want.mean));
          if (out_data_i.rms !== want.rms) report("rms", out_data_i.rms, want.rms);
          if (out_data_i.deviation !== want.deviation)
            report("deviation", out_data_i.deviation, want.deviation);
          if (out_data_i.sample_count !== want.sample_count)
            report("sample_count", out_data_i.sample_count, want.sample_count);
          if (out_data_i.window_full !== want.window_full)
            report("window_full", out_data_i.window_full, want.window_full);
        end
      end
    end
  end

endmodule

// ===== bench/moving_window_statistics_core_tb.sv =====
// ----------------------------------------------------------------------------
// moving_window_statistics_core_tb
// drives directed and random sample streams over several window lengths,
// including out of range lengths and shrinking without clear, with random
// gaps and a long output hold-off; the checker predicts and compares
// ----------------------------------------------------------------------------
module moving_window_statistics_core_tb;

  import mws_pkg::*;
  import mws_tb_pkg::*;

  localparam int StallLimit = 50000;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;
  int              pending;
  int              errors;
  int              accepted;
  int              idle_cycles;
  bit              hold_done;

  mws_if #(.payload_t(sample_in_t)) in_ch ();
  mws_if #(.payload_t(stats_out_t)) out_ch ();

  moving_window_statistics_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  moving_window_statistics_core_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return SampleBits'($urandom_range(0, 6) - 3);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task automatic send(logic cmd, logic [SampleBits-1:0] s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{command: cmd, sample: s};
    do @(posedge clk_i); while (!in_ch.ready);
    accepted++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_length(logic [LenW-1:0] len);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_stream(int n, int clear_odds);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, clear_odds) == 1) send(CmdClear, SampleBits'($urandom));
      else send(CmdPush, pick_sample());
    end
  endtask

  task automatic window_phase(logic [LenW-1:0] len, int n, int clear_odds);
    set_length(len);
    send(CmdClear, '0);
    run_stream(n, clear_odds);
  endtask

  // receiver side with one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted >= 300) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      if (accepted > 900 && accepted < 1000) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 9) < 3) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 19) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 100)) @(posedge clk_i);
      end else out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("moving_window_statistics_core test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    accepted = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, empty window, clear with nonzero sample
    send(CmdClear, 16'hffff);
    send(CmdPush, 16'h7fff);
    send(CmdPush, 16'h8000);
    send(CmdPush, 16'h0000);
    send(CmdPush, 16'hffff);
    send(CmdPush, 16'h0001);
    send(CmdClear, 16'h0000);
    repeat (3) send(CmdPush, 16'h8000);
    send(CmdClear, 16'h5555);
    repeat (3) send(CmdPush, 16'h7fff);
    set_length(10'd2);
    send(CmdClear, '0);
    send(CmdPush, 16'h8000);
    send(CmdPush, 16'h7fff);
    send(CmdPush, 16'h8000);
    send(CmdPush, 16'haaaa);

    // length range, zero and above the store size
    window_phase(10'd1, 60, 30);
    window_phase(10'd0, 40, 30);
    window_phase(10'd3, 100, 40);
    window_phase(10'd1023, 40, 100);
    window_phase(10'd700, 30, 100);
    window_phase(10'd512, 560, 100000);

    // shrink below count without clear, then grow
    window_phase(10'd32, 40, 100000);
    set_length(10'd4);
    run_stream(40, 100000);
    set_length(10'd64);
    run_stream(40, 100000);

    for (int p = 0; p < 8; p++)
      window_phase(LenW'($urandom_range(1, 40)), 50, 25);

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("moving_window_statistics_core test passed");
    else $display("moving_window_statistics_core test failed");
    $finish;
  end

endmodule
